// ----- rtl/lms_pkg.sv -----
// Shared types and constants for the LMS linear classifier training unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lms_pkg;

   // Default sizing of the weight table and the stored weight width.
   localparam int MAX_DIM_DEF    = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Reset values of the configuration registers.
   localparam logic [4:0]  DIM_RESET  = 5'd16;
   localparam logic [15:0] STEP_RESET = 16'd655;

   // Register selects, taken from address bit 2.
   localparam logic REG_DIMENSION = 1'b0;
   localparam logic REG_STEP_SIZE = 1'b1;

   // Result status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_INDEX = 1'b1;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_FEATURE = 2'd2,
      CMD_TARGET  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [4:0]         index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic signed [31:0] correction;
      logic               status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_DOT,
      ST_PRED,
      ST_ERR,
      ST_CORR,
      ST_UPD
   } st_type;

   typedef enum logic {
      MAC_ACC,
      MAC_ADD
   } mac_op_type;

   typedef struct packed {
      logic       issue;
      mac_op_type op;
      logic       load;
   } mac_ctl_type;

   typedef struct packed {
      logic pending;
      logic res_valid;
   } mac_sts_type;

endpackage

`default_nettype wire

// ----- rtl/lms_linear_classifier_training_unit.sv -----
// Top level of the LMS (Widrow-Hoff) linear classifier training unit.
// Depends on lms_pkg, lms_csr and lms_mac; holds the weight and feature tables.
`default_nettype none

// A write, feature or out-of-range request finishes in the decode state, a weight-table
// read goes on through the read state, and a target walks the features in use for the dot
// product and again for the weight update. One request at a time: busy stays high until
// the result strobe, and the next request can be taken in the strobe cycle. Synchronous
// active-high reset clears the sequencer, the weight valid bits, the bias and the
// registers, not the features. Results cannot be stalled.
module lms_linear_classifier_training_unit
   import lms_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_item,
   // Result channel
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   // Configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   // Weights saturate to EffW bits; the ports carry 32.
   localparam int EffW    = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
   localparam int AddrW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CntW    = $clog2(MAX_DIM + 1);
   localparam int IdxExtW = (AddrW > 5) ? AddrW : 5;
   localparam logic signed [33:0] SatMax = {{(35 - EffW){1'b0}}, {(EffW - 1){1'b1}}};
   localparam logic signed [33:0] SatMin = ~SatMax;

   function automatic logic signed [EffW-1:0] sat_to_w(input logic signed [33:0] v);
      logic signed [EffW-1:0] r;
      if (v > SatMax) begin
         r = SatMax[EffW-1:0];
      end else if (v < SatMin) begin
         r = SatMin[EffW-1:0];
      end else begin
         r = v[EffW-1:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic [4:0]  dimension;
   logic [15:0] step_size;

   lms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .dimension (dimension),
      .step_size (step_size)
   );

   // Sequencer state and working registers.
   st_type                 state_ff, state_in;
   req_type                req_ff;
   logic [CntW-1:0]        rd_cnt_ff, rd_cnt_in;
   logic                   rd_vld_ff;
   logic [AddrW-1:0]       a1_ff, a2_ff, a3_ff;
   logic signed [EffW-1:0] data_ff, data_in;
   logic signed [EffW-1:0] corr_ff, corr_in;
   logic signed [EffW-1:0] bias_ff, bias_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Table ports.
   logic signed [EffW-1:0] wgt_mem [MAX_DIM];
   logic [MAX_DIM-1:0]     wgt_vld_ff;
   logic signed [31:0]     feat_mem [MAX_DIM];
   logic                   wgt_we, feat_we, rd_issue;
   logic [AddrW-1:0]       wgt_waddr, feat_waddr, rd_addr;
   logic signed [EffW-1:0] wgt_wdata;
   logic signed [EffW-1:0] wgt_q_ff;
   logic                   wgt_qv_ff;
   logic signed [EffW-1:0] wgt_rd;
   logic signed [31:0]     feat_q_ff;

   // Shared multiply unit.
   mac_ctl_type            mac_ctl;
   mac_sts_type            mac_sts;
   logic signed [33:0]     mac_a;
   logic signed [31:0]     mac_b;
   logic signed [EffW-1:0] mac_addend;
   logic signed [EffW-1:0] mac_pred;
   logic signed [EffW-1:0] mac_res;

   lms_mac #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .a        (mac_a),
      .b        (mac_b),
      .addend   (mac_addend),
      .acc_init (bias_ff),
      .pred     (mac_pred),
      .res      (mac_res),
      .sts      (mac_sts)
   );

   // Index decode of the latched request.
   logic [IdxExtW-1:0] idx_ext;
   logic [AddrW-1:0]   idx_addr;
   logic               idx_in_table;
   logic               idx_is_bias;
   logic [CntW-1:0]    dim_eff;

   assign idx_ext      = IdxExtW'(req_ff.index);
   assign idx_addr     = idx_ext[AddrW-1:0];
   assign idx_in_table = (32'(req_ff.index) < MAX_DIM);
   assign idx_is_bias  = (32'(req_ff.index) == MAX_DIM);
   // A dimension above the table size uses the whole table.
   assign dim_eff      = (32'(dimension) > MAX_DIM) ? CntW'(MAX_DIM) : CntW'(dimension);

   // Weights that were never written since reset read as zero.
   assign wgt_rd = wgt_qv_ff ? wgt_q_ff : '0;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bias_ff      <= '0;
         wgt_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_issue;
         rsp_valid_ff <= rsp_valid_in;
         bias_ff      <= bias_in;
         if (wgt_we) begin
            wgt_vld_ff[wgt_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_item;
      end
      rd_cnt_ff <= rd_cnt_in;
      a1_ff     <= rd_addr;
      a2_ff     <= a1_ff;
      a3_ff     <= a2_ff;
      data_ff   <= data_in;
      corr_ff   <= corr_in;
      rsp_ff    <= rsp_in;
   end

   // Weight table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem[wgt_waddr] <= wgt_wdata;
      end
      wgt_q_ff  <= wgt_mem[rd_addr];
      wgt_qv_ff <= wgt_vld_ff[rd_addr];
   end

   // Feature buffer: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem[feat_waddr] <= req_ff.value;
      end
      feat_q_ff <= feat_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      rd_cnt_in    = rd_cnt_ff;
      data_in      = data_ff;
      corr_in      = corr_ff;
      bias_in      = bias_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      rd_issue     = 1'b0;
      rd_addr      = rd_cnt_ff[AddrW-1:0];
      wgt_we       = 1'b0;
      wgt_waddr    = a3_ff;
      wgt_wdata    = mac_res;
      feat_we      = 1'b0;
      feat_waddr   = idx_addr;
      mac_ctl      = '{issue: 1'b0, op: MAC_ACC, load: 1'b0};
      mac_a        = {{(34 - EffW){wgt_rd[EffW-1]}}, wgt_rd};
      mac_b        = feat_q_ff;
      mac_addend   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            // Every command except a table read or a target finishes here.
            rsp_in       = '{data: '0, correction: '0, status: STATUS_OK};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            case (req_ff.cmd)
               CMD_WRITE: begin
                  if (idx_in_table) begin
                     wgt_we    = 1'b1;
                     wgt_waddr = idx_addr;
                     wgt_wdata = sat_to_w({{2{req_ff.value[31]}}, req_ff.value});
                  end else if (idx_is_bias) begin
                     bias_in = sat_to_w({{2{req_ff.value[31]}}, req_ff.value});
                  end else begin
                     rsp_in.status = STATUS_BAD_INDEX;
                  end
               end
               CMD_READ: begin
                  if (idx_in_table) begin
                     rd_addr      = idx_addr;
                     rsp_valid_in = 1'b0;
                     state_in     = ST_READ;
                  end else if (idx_is_bias) begin
                     rsp_in.data = 32'(bias_ff);
                  end else begin
                     rsp_in.status = STATUS_BAD_INDEX;
                  end
               end
               CMD_FEATURE: begin
                  if (idx_in_table) begin
                     feat_we = 1'b1;
                  end else begin
                     rsp_in.status = STATUS_BAD_INDEX;
                  end
               end
               CMD_TARGET: begin
                  // Seed the accumulator with the bias, then walk the features.
                  mac_ctl.load = 1'b1;
                  rd_cnt_in    = '0;
                  rsp_valid_in = 1'b0;
                  state_in     = ST_DOT;
               end
               default: begin
                  rsp_in.status = STATUS_BAD_INDEX;
               end
            endcase
         end

         ST_READ: begin
            rsp_in       = '{data: 32'(wgt_rd), correction: '0, status: STATUS_OK};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_DOT: begin
            if (rd_cnt_ff != dim_eff) begin
               rd_issue  = 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               mac_ctl.issue = 1'b1;
               mac_ctl.op    = MAC_ACC;
            end
            if ((rd_cnt_ff == dim_eff) && !rd_vld_ff && !mac_sts.pending) begin
               state_in = ST_PRED;
            end
         end

         ST_PRED: begin
            data_in  = mac_pred;
            state_in = ST_ERR;
         end

         ST_ERR: begin
            // Error is exact in 34 bits; the unit rounds and saturates step * error.
            mac_ctl.issue = 1'b1;
            mac_ctl.op    = MAC_ADD;
            mac_a         = {{2{req_ff.value[31]}}, req_ff.value}
                          - {{(34 - EffW){data_ff[EffW-1]}}, data_ff};
            mac_b         = {16'd0, step_size};
            state_in      = ST_CORR;
         end

         ST_CORR: begin
            if (mac_sts.res_valid) begin
               corr_in   = mac_res;
               bias_in   = sat_to_w({{(34 - EffW){bias_ff[EffW-1]}}, bias_ff}
                                  + {{(34 - EffW){mac_res[EffW-1]}}, mac_res});
               rd_cnt_in = '0;
               state_in  = ST_UPD;
            end
         end

         ST_UPD: begin
            if (rd_cnt_ff != dim_eff) begin
               rd_issue  = 1'b1;
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               mac_ctl.issue = 1'b1;
               mac_ctl.op    = MAC_ADD;
               mac_a         = {{(34 - EffW){corr_ff[EffW-1]}}, corr_ff};
               mac_addend    = wgt_rd;
            end
            // Updated weights come back through the read, product and result registers.
            if (mac_sts.res_valid) begin
               wgt_we = 1'b1;
            end
            if ((rd_cnt_ff == dim_eff) && !rd_vld_ff && !mac_sts.pending
                && !mac_sts.res_valid) begin
               rsp_in       = '{data: 32'(data_ff), correction: 32'(corr_ff),
                                status: STATUS_OK};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding work");

   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == STATUS_BAD_INDEX))
      |-> ((rsp_item.data == '0) && (rsp_item.correction == '0)))
      else $error("out-of-range request returned nonzero data");

   a_weight_write_state: assert property (@(posedge clock) disable iff (reset)
      wgt_we |-> ((state_ff == ST_DECODE) || (state_ff == ST_UPD)))
      else $error("weight table written outside a write or update");

endmodule

`default_nettype wire

// ----- rtl/lms_csr.sv -----
// Configuration registers (dimension, step size) behind an APB-style port.
// Depends on lms_pkg for reset values and register selects.
`default_nettype none

module lms_csr
   import lms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output logic      [4:0]  dimension,
   output logic      [15:0] step_size
);

   logic [4:0]  dimension_ff;
   logic [15:0] step_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= DIM_RESET;
         step_ff      <= STEP_RESET;
      end else if (wr_en) begin
         if (paddr[2] == REG_DIMENSION) begin
            dimension_ff <= pwdata[4:0];
         end else begin
            step_ff <= pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_STEP_SIZE) begin
         prdata = {16'd0, step_ff};
      end else begin
         prdata = {27'd0, dimension_ff};
      end
   end

   assign dimension = dimension_ff;
   assign step_size = step_ff;

endmodule

`default_nettype wire

// ----- rtl/lms_mac.sv -----
// Shared multiply unit: one registered 34x32 product, Q16.16 rounding, and
// either an exact accumulator or a saturating add. Depends on lms_pkg.
`default_nettype none

module lms_mac
   import lms_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mac_ctl_type                  ctl,
   input  wire logic signed [33:0]           a,
   input  wire logic signed [31:0]           b,
   input  wire logic signed [((DATA_WIDTH > 32) ? 32 : DATA_WIDTH)-1:0] addend,
   input  wire logic signed [((DATA_WIDTH > 32) ? 32 : DATA_WIDTH)-1:0] acc_init,
   output logic signed [((DATA_WIDTH > 32) ? 32 : DATA_WIDTH)-1:0]      pred,
   output logic signed [((DATA_WIDTH > 32) ? 32 : DATA_WIDTH)-1:0]      res,
   output mac_sts_type                       sts
);

   localparam int EffW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
   localparam int CntW = $clog2(MAX_DIM + 1);
   // Rounded products are 49 bits; the sum of all terms plus the bias fits here.
   localparam int AccW = 50 + CntW;
   localparam logic signed [AccW-1:0] SatMax =
      {{(AccW - EffW + 1){1'b0}}, {(EffW - 1){1'b1}}};
   localparam logic signed [AccW-1:0] SatMin = ~SatMax;

   function automatic logic signed [EffW-1:0] sat_acc(input logic signed [AccW-1:0] v);
      logic signed [EffW-1:0] r;
      if (v > SatMax) begin
         r = SatMax[EffW-1:0];
      end else if (v < SatMin) begin
         r = SatMin[EffW-1:0];
      end else begin
         r = v[EffW-1:0];
      end
      return r;
   endfunction

   logic                    vld_ff;
   logic                    res_vld_ff;
   mac_op_type              op_ff;
   logic signed [64:0]      prod_ff;
   logic signed [EffW-1:0]  addend_ff;
   logic signed [AccW-1:0]  acc_ff;
   logic signed [EffW-1:0]  res_ff;
   logic signed [64:0]      prod_in;
   logic signed [64:0]      biased;
   logic signed [48:0]      rnd;
   logic signed [49:0]      add_sum;

   assign prod_in = a * b;
   // Round half up: add one half LSB of Q16.16, then floor by taking high bits.
   assign biased  = prod_ff + 65'sd32768;
   assign rnd     = biased[64:16];
   assign add_sum = {{(50 - EffW){addend_ff[EffW-1]}}, addend_ff} + {rnd[48], rnd};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= ctl.issue;
         res_vld_ff <= vld_ff && (op_ff == MAC_ADD);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      op_ff     <= ctl.op;
      addend_ff <= addend;
      if (ctl.load) begin
         acc_ff <= {{(AccW - EffW){acc_init[EffW-1]}}, acc_init};
      end else if (vld_ff && (op_ff == MAC_ACC)) begin
         acc_ff <= acc_ff + {{(AccW - 49){rnd[48]}}, rnd};
      end
      if (vld_ff && (op_ff == MAC_ADD)) begin
         res_ff <= sat_acc({{(AccW - 50){add_sum[49]}}, add_sum});
      end
   end

   assign pred          = sat_acc(acc_ff);
   assign res           = res_ff;
   assign sts.pending   = vld_ff;
   assign sts.res_valid = res_vld_ff;

   a_res_from_add: assert property (@(posedge clock) disable iff (reset)
      res_vld_ff |-> ($past(ctl.issue, 2) && ($past(ctl.op, 2) == MAC_ADD)))
      else $error("mac result without a matching add issue");

   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> !(vld_ff && (op_ff == MAC_ACC)))
      else $error("accumulator load collides with a pending accumulate");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the LMS linear classifier training unit.
// Depends on lms_pkg and lms_linear_classifier_training_unit; a small class
// predicts every result in Q16.16 and checks what the block returns.

import lms_pkg::*;

// Tracks the weight table, the feature buffer and both registers, and keeps
// the results that accepted requests are still owed.
class lms_training_checker;
   longint      weight_mem[MAX_DIM_DEF + 1];
   longint      feature_mem[MAX_DIM_DEF];
   logic [4:0]  dimension;
   logic [15:0] step_size;
   rsp_type     pending_results[$];
   int          mismatches;
   int          results_checked;
   int          targets_seen;

   function new();
      foreach (weight_mem[i]) weight_mem[i] = 0;
      foreach (feature_mem[i]) feature_mem[i] = 0;
      dimension = DIM_RESET;
      step_size = STEP_RESET;
      mismatches = 0;
      results_checked = 0;
      targets_seen = 0;
   endfunction

   function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("tb_top: mismatch: %s", what);
   endfunction

   static function longint clamp32(longint v);
      longint hi;
      longint lo;
      hi = 2147483647;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Round half up to Q16.16: floor((v + 2^15) / 2^16).
   static function longint round_q16(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function void set_register(logic sel, logic [31:0] v);
      if (sel == REG_DIMENSION) dimension = v[4:0];
      else step_size = v[15:0];
   endfunction

   function void check_register(logic sel, logic [31:0] got);
      if (sel == REG_DIMENSION && got[4:0] !== dimension)
         flag($sformatf("dimension reads %0d, expected %0d", got[4:0], dimension));
      if (sel == REG_STEP_SIZE && got[15:0] !== step_size)
         flag($sformatf("step_size reads %0d, expected %0d", got[15:0], step_size));
   endfunction

   function void note_request(req_type r);
      rsp_type res;
      longint  val;
      longint  acc;
      longint  pred;
      longint  corr;
      longint  step;
      int      d;
      res = '0;
      val = $signed(r.value);
      step = step_size;
      case (r.cmd)
         CMD_WRITE: begin
            if (r.index <= MAX_DIM_DEF) weight_mem[r.index] = clamp32(val);
            else res.status = STATUS_BAD_INDEX;
         end
         CMD_READ: begin
            if (r.index <= MAX_DIM_DEF) res.data = 32'(weight_mem[r.index]);
            else res.status = STATUS_BAD_INDEX;
         end
         CMD_FEATURE: begin
            if (r.index < MAX_DIM_DEF) feature_mem[r.index] = val;
            else res.status = STATUS_BAD_INDEX;
         end
         default: begin
            // A dimension above the table size behaves as the table size.
            d = (dimension > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(dimension);
            acc = weight_mem[MAX_DIM_DEF];
            for (int j = 0; j < d; j++)
               acc += round_q16(feature_mem[j] * weight_mem[j]);
            pred = clamp32(acc);
            corr = clamp32(round_q16((val - pred) * step));
            for (int j = 0; j < d; j++)
               weight_mem[j] = clamp32(weight_mem[j] + round_q16(corr * feature_mem[j]));
            weight_mem[MAX_DIM_DEF] = clamp32(weight_mem[MAX_DIM_DEF] + corr);
            res.data = 32'(pred);
            res.correction = 32'(corr);
            targets_seen++;
         end
      endcase
      pending_results.push_back(res);
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      results_checked++;
      if (pending_results.size() == 0) begin
         flag($sformatf("result with nothing outstanding: data %h corr %h status %b",
                        got.data, got.correction, got.status));
         return;
      end
      want = pending_results.pop_front();
      if (got.data !== want.data)
         flag($sformatf("data %h, expected %h", got.data, want.data));
      if (got.correction !== want.correction)
         flag($sformatf("correction %h, expected %h", got.correction, want.correction));
      if (got.status !== want.status)
         flag($sformatf("status %b, expected %b", got.status, want.status));
   endfunction
endclass

module tb_top;

   // Every input of the block starts at a known value, reset asserted.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   lms_training_checker board = new();

   // Percentage of cycles in which the sender holds back the next request.
   int idle_pct = 0;
   int requests_sent = 0;
   int settings_written = 0;

   // Per-phase register settings; the extremes of both registers appear,
   // including a zero dimension and dimensions beyond the table size.
   int unsigned dim_plan[10]  = '{16, 1, 0, 31, 3, 17, 8, 16, 2, 5};
   int unsigned step_plan[10] = '{655, 65535, 0, 1, 32768, 4096, 65535, 0, 1000, 20000};

   lms_linear_classifier_training_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Outputs are sampled at the rising edge, before the block's own updates
   // for that edge land, so every result is seen in the cycle it is shown.
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_item);
   end

   // Random pause before a request. start is lowered only when a pause is
   // actually taken, so a back-to-back request keeps start high without a
   // second assignment in the same step.
   task automatic idle_gap();
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Presents one request and holds it until the block takes it, which is
   // the first rising edge with start high and busy low.
   task automatic send_request(cmd_type c, logic [4:0] idx, logic [31:0] val);
      req_type r;
      idle_gap();
      r.cmd = c;
      r.index = idx;
      r.value = val;
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_request(r);
      requests_sent++;
   endtask

   // Drops start and waits until every owed result has come back. Every
   // request yields exactly one result, so an empty queue means the block
   // has nothing in flight.
   task automatic wait_idle();
      start <= 1'b0;
      while (board.pending_results.size() != 0 || busy) @(posedge clock);
   endtask

   // APB write (setup then access), followed by a read back of the register.
   task automatic write_register(logic sel, logic [31:0] val);
      logic [31:0] readback;
      wait_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_register(sel, val);
      settings_written++;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      board.check_register(sel, readback);
   endtask

   // Mostly modest Q16.16 values within +/-4.0 so that training does not pin
   // the weights at saturation; now and then raw bits or a range extreme.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'($urandom_range(8 * 65536)) - 32'd262144;
      endcase
   endfunction

   // One well-formed training sample: the features in use, sometimes a
   // feature beyond the current dimension, then the target that ends it.
   task automatic train_sample();
      int          d;
      logic [31:0] target;
      d = (board.dimension > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(board.dimension);
      for (int j = 0; j < d; j++) send_request(CMD_FEATURE, 5'(j), pick_value());
      if (d < MAX_DIM_DEF && $urandom_range(3) == 0)
         send_request(CMD_FEATURE, 5'($urandom_range(MAX_DIM_DEF - 1, d)), pick_value());
      case ($urandom_range(3))
         0: target = 32'h0001_0000;
         1: target = 32'hFFFF_0000;
         default: target = pick_value();
      endcase
      send_request(CMD_TARGET, 5'($urandom_range(31)), target);
   endtask

   initial begin
      int          phase_end;
      int          pick;
      logic [4:0]  slot;
      logic [31:0] raw;

      // Reset is held at the start and never raised again.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset settings (dimension 16). Every feature is
      // written first, so no later target ever reads an unwritten entry.
      for (int j = 0; j < MAX_DIM_DEF; j++) begin
         if (j == 0) raw = 32'h7FFF_FFFF;
         else if (j == 1) raw = 32'h8000_0000;
         else raw = 32'((j - 8) * 16384);
         send_request(CMD_FEATURE, 5'(j), raw);
      end
      send_request(CMD_READ, 5'd0, 32'd0);                 // weights read zero after reset
      send_request(CMD_WRITE, 5'd0, 32'h7FFF_FFFF);        // largest weight
      send_request(CMD_WRITE, 5'(MAX_DIM_DEF), 32'h8000_0000); // smallest bias
      send_request(CMD_WRITE, 5'd31, 32'h1234_5678);       // weight index out of range
      send_request(CMD_READ, 5'd0, 32'hFFFF_FFFF);
      send_request(CMD_READ, 5'd17, 32'd0);                // read index out of range
      send_request(CMD_FEATURE, 5'(MAX_DIM_DEF), 32'hDEAD_BEEF); // feature index too big
      send_request(CMD_FEATURE, 5'd31, 32'h0000_0001);
      send_request(CMD_TARGET, 5'd0, 32'h0001_0000);       // class +1
      send_request(CMD_TARGET, 5'd31, 32'hFFFF_0000);      // class -1
      send_request(CMD_TARGET, 5'd5, 32'h7FFF_FFFF);       // extreme targets
      send_request(CMD_TARGET, 5'd16, 32'h8000_0000);

      // Random part in phases. Each phase after the first starts from an idle block with
      // a new register setting; the sender idling pattern cycles through three settings.
      for (int p = 0; p < 10; p++) begin
         if (p > 0) begin
            write_register(REG_DIMENSION, ($urandom() & ~32'h1F) | dim_plan[p]);
            write_register(REG_STEP_SIZE, ($urandom() & ~32'hFFFF) | step_plan[p]);
         end
         case (p % 3)
            0: idle_pct = 0;
            1: idle_pct = 84;
            default: idle_pct = 23;
         endcase
         phase_end = requests_sent + 162;
         while (requests_sent < phase_end) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
               train_sample();
            end else if (pick < 8) begin
               // Software-style weight reload and read back, bias included.
               slot = 5'($urandom_range(MAX_DIM_DEF));
               send_request(CMD_WRITE, slot, pick_value());
               send_request(CMD_READ, slot, $urandom());
            end else begin
               // Noise: any command, any index, raw value.
               send_request(cmd_type'($urandom_range(3)), 5'($urandom_range(31)), $urandom());
            end
         end
      end

      // Drain, then let the longest target latency pass once more.
      wait_idle();
      repeat (64) @(posedge clock);

      $display("tb_top: %0d requests, %0d results checked, %0d of them training targets",
               requests_sent, board.results_checked, board.targets_seen);
      $display("tb_top: %0d register writes over 10 phases, %0d mismatches",
               settings_written, board.mismatches);
      if (board.mismatches == 0 && board.pending_results.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run.
   initial begin
      #8000000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
